>>> src/wnlt_pkg.sv
// ----------------------------------------------------------------------------
// wnlt_pkg
// Shared types, codes and helpers of the wildcard name lookup table.
// ----------------------------------------------------------------------------
package wnlt_pkg;

   localparam int CHAR_W      = 8;
   localparam int MAX_CHARS   = 8;
   localparam int STATUS_W    = 3;
   localparam int IDX_OUT_W   = 6;
   localparam int TOT_OUT_W   = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   localparam logic [CHAR_W-1:0] WILD_CHAR  = 8'h3F;
   localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;
   localparam logic              REQ_INSERT = 1'b0;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_FULL     = 3'd1,
      ST_MATCH    = 3'd2,
      ST_NOMATCH  = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_EMPTY  = 2'd2
   } op_kind_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'd0,
      S_SCAN   = 3'd1,
      S_DRAIN  = 3'd2,
      S_DECIDE = 3'd3,
      S_WALK   = 3'd4
   } state_type;

   function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

endpackage

>>> src/wnlt_ram.sv
// ----------------------------------------------------------------------------
// wnlt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wnlt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/wnlt_front.sv
// ----------------------------------------------------------------------------
// wnlt_front
// Classify a request word and pack its name, zeroing characters past the end.
// ----------------------------------------------------------------------------
module wnlt_front
   import wnlt_pkg::*;
#(
   parameter int NAME_CHARS = 8
) (
   input  logic                         req_type,
   input  logic [CHAR_W-1:0]            req_char0,
   input  logic [CHAR_W-1:0]            req_char1,
   input  logic [CHAR_W-1:0]            req_char2,
   input  logic [CHAR_W-1:0]            req_char3,
   input  logic [CHAR_W-1:0]            req_char4,
   input  logic [CHAR_W-1:0]            req_char5,
   input  logic [CHAR_W-1:0]            req_char6,
   input  logic [CHAR_W-1:0]            req_char7,
   output op_kind_type                  kind,
   output logic [NAME_CHARS*CHAR_W-1:0] name
);

   logic [CHAR_W-1:0] chars [MAX_CHARS];

   assign chars[0] = req_char0;
   assign chars[1] = req_char1;
   assign chars[2] = req_char2;
   assign chars[3] = req_char3;
   assign chars[4] = req_char4;
   assign chars[5] = req_char5;
   assign chars[6] = req_char6;
   assign chars[7] = req_char7;

   always_comb begin
      logic alive;
      alive = 1'b1;
      name  = '0;
      for (int k = 0; k < NAME_CHARS; k++) begin
         alive = alive && (chars[k] != NUL_CHAR);
         name[k*CHAR_W +: CHAR_W] = alive ? chars[k] : NUL_CHAR;
      end
   end

   always_comb begin
      if (req_type == REQ_INSERT) begin
         kind = OP_INSERT;
      end else if (chars[0] == NUL_CHAR) begin
         kind = OP_EMPTY;
      end else begin
         kind = OP_LOOKUP;
      end
   end

endmodule

>>> src/wnlt_queue.sv
// ----------------------------------------------------------------------------
// wnlt_queue
// Two-entry queue between the classifier and the lookup engine.
// ----------------------------------------------------------------------------
module wnlt_queue
   import wnlt_pkg::*;
#(
   parameter int WIDTH = 66
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0]  slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic              push, pop;

   assign push_ready = (fill_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/wnlt_back.sv
// ----------------------------------------------------------------------------
// wnlt_back
// Lookup engine: append names, scan the table for matches, emit result words.
// ----------------------------------------------------------------------------
module wnlt_back
   import wnlt_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int NAME_CHARS  = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   output logic                         q_ready,
   input  op_kind_type                  q_kind,
   input  logic [NAME_CHARS*CHAR_W-1:0] q_name,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [IDX_OUT_W-1:0]         rsp_entry_index,
   output logic [TOT_OUT_W-1:0]         rsp_match_total,
   output logic                         rsp_last
);

   localparam int NAME_W = NAME_CHARS * CHAR_W;
   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [NAME_W-1:0]      key_ff, key_in;
   logic [IDX_W-1:0]       scan_idx_ff, scan_idx_in;
   logic                   pend_ff, pend_in;
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic [TABLE_DEPTH-1:0] match_vec_ff, match_vec_in;
   logic [CNT_W-1:0]       total_ff, total_in;
   logic [CNT_W-1:0]       left_ff, left_in;
   logic [IDX_W-1:0]       walk_idx_ff, walk_idx_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff;
   logic [IDX_W-1:0]       rsp_index_ff;
   logic [CNT_W-1:0]       rsp_total_ff;
   logic                   rsp_last_ff;

   logic                   out_free;
   logic                   table_full;
   logic                   count_zero;
   logic                   walk_bit;
   logic [IDX_W-1:0]       top_idx;
   logic                   ram_we, ram_re;
   logic [NAME_W-1:0]      rd_name;
   logic                   hit;
   logic                   res_load;
   status_type             res_status;
   logic [IDX_W-1:0]       res_idx;
   logic [CNT_W-1:0]       res_total;
   logic                   res_last;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign table_full = (count_ff >= CNT_W'(TABLE_DEPTH));
   assign count_zero = (count_ff == '0);
   assign walk_bit   = match_vec_ff[walk_idx_ff];
   assign top_idx    = IDX_W'(count_ff - 1'b1);

   wnlt_ram #(
      .WIDTH (NAME_W),
      .DEPTH (TABLE_DEPTH)
   ) u_name_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (q_name),
      .rd_en   (ram_re),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_name)
   );

   always_comb begin
      logic [CHAR_W-1:0] a, b;
      logic              ok, term, prefix;
      prefix = 1'b1;
      hit    = 1'b0;
      for (int i = 0; i < NAME_CHARS; i++) begin
         a    = key_ff[i*CHAR_W +: CHAR_W];
         b    = rd_name[i*CHAR_W +: CHAR_W];
         ok   = (a != NUL_CHAR) && (b != NUL_CHAR) &&
                ((fold_case(a) == fold_case(b)) || (a == WILD_CHAR) || (b == WILD_CHAR));
         term = !ok && ((a == WILD_CHAR) || (b == WILD_CHAR) ||
                        ((a == NUL_CHAR) && (b == NUL_CHAR)));
         hit    = hit || (prefix && term);
         prefix = prefix && ok;
      end
      hit = hit || prefix;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && q_kind == OP_LOOKUP && !count_zero) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_idx_ff == '0) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (total_ff != '0) begin
               state_in = S_WALK;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_WALK: begin
            if (walk_bit && out_free && left_ff == CNT_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      q_ready    = 1'b0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      res_load   = 1'b0;
      res_status = ST_INSERTED;
      res_idx    = '0;
      res_total  = '0;
      res_last   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               unique case (q_kind)
                  OP_INSERT: begin
                     if (out_free) begin
                        q_ready  = 1'b1;
                        res_load = 1'b1;
                        if (table_full) begin
                           res_status = ST_FULL;
                        end else begin
                           ram_we     = 1'b1;
                           res_status = ST_INSERTED;
                           res_idx    = count_ff[IDX_W-1:0];
                        end
                     end
                  end
                  OP_EMPTY: begin
                     if (out_free) begin
                        q_ready    = 1'b1;
                        res_load   = 1'b1;
                        res_status = ST_EMPTY;
                     end
                  end
                  OP_LOOKUP: begin
                     if (!count_zero) begin
                        q_ready = 1'b1;
                     end else if (out_free) begin
                        q_ready    = 1'b1;
                        res_load   = 1'b1;
                        res_status = ST_NOMATCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            ram_re = 1'b1;
         end
         S_DRAIN: ;
         S_DECIDE: begin
            if (total_ff == '0 && out_free) begin
               res_load   = 1'b1;
               res_status = ST_NOMATCH;
            end
         end
         S_WALK: begin
            if (walk_bit && out_free) begin
               res_load   = 1'b1;
               res_status = ST_MATCH;
               res_idx    = walk_idx_ff;
               res_total  = total_ff;
               res_last   = (left_ff == CNT_W'(1));
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      count_in     = ram_we ? count_ff + 1'b1 : count_ff;
      key_in       = key_ff;
      scan_idx_in  = scan_idx_ff;
      pend_in      = (state_ff == S_SCAN);
      pend_idx_in  = scan_idx_ff;
      match_vec_in = match_vec_ff;
      total_in     = total_ff;
      left_in      = left_ff;
      walk_idx_in  = walk_idx_ff;
      if (state_ff == S_IDLE && state_in == S_SCAN) begin
         key_in       = q_name;
         scan_idx_in  = top_idx;
         match_vec_in = '0;
         total_in     = '0;
      end else if (state_ff == S_SCAN) begin
         scan_idx_in = scan_idx_ff - 1'b1;
      end
      if (pend_ff && hit) begin
         match_vec_in[pend_idx_ff] = 1'b1;
         total_in                  = total_ff + 1'b1;
      end
      if (state_ff == S_DECIDE) begin
         walk_idx_in = top_idx;
         left_in     = total_ff;
      end else if (state_ff == S_WALK) begin
         if (!walk_bit || out_free) begin
            walk_idx_in = walk_idx_ff - 1'b1;
         end
         if (res_load) begin
            left_in = left_ff - 1'b1;
         end
      end
      rsp_valid_in = res_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         total_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         total_ff     <= total_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff       <= key_in;
      scan_idx_ff  <= scan_idx_in;
      pend_idx_ff  <= pend_idx_in;
      match_vec_ff <= match_vec_in;
      walk_idx_ff  <= walk_idx_in;
      if (res_load) begin
         rsp_status_ff <= res_status;
         rsp_index_ff  <= res_idx;
         rsp_total_ff  <= res_total;
         rsp_last_ff   <= res_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = IDX_OUT_W'(rsp_index_ff);
   assign rsp_match_total = TOT_OUT_W'(rsp_total_ff);
   assign rsp_last        = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_IDLE) && !table_full)
      else $error("name store written outside idle or when full");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= count_ff)
      else $error("match total exceeds entry count");

   a_walk_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (left_ff != '0))
      else $error("walking with no matches left");

   a_match_bit: assert property (@(posedge clock) disable iff (reset)
      (res_load && state_ff == S_WALK) |-> walk_bit && (res_idx <= top_idx))
      else $error("match word emitted for an entry that did not match");

endmodule

>>> src/wildcard_name_lookup_table_unit.sv
// ----------------------------------------------------------------------------
// wildcard_name_lookup_table_unit
// Table of short names with case-blind, wildcard lookup.
// ----------------------------------------------------------------------------
// Request channel (req_*): an insert word appends its name as the next entry
// (or reports ST_FULL); a lookup word returns one rsp word per matching entry,
// highest index first, with rsp_last on the final one. Inserts, empty-name
// lookups and lookups that find nothing give a single word.
// Requests enter a two-word queue, so up to two may be taken while the engine
// is busy or the response register is stalled.
// An insert or empty-name lookup, given an idle engine, passes through the
// queue and then the response register. A lookup over N stored entries reads
// the name store once per entry (one read port, one entry a cycle), then walks
// the recorded match bits one entry a cycle, except that it holds on a match
// while the response register is stalled.
// A stalled response holds its word and stops the engine whenever it has a
// word to give; the queue keeps taking requests until full.
// Reset empties the table and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module wildcard_name_lookup_table_unit
   import wnlt_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int NAME_CHARS  = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   input  logic [CHAR_W-1:0]    req_char0,
   input  logic [CHAR_W-1:0]    req_char1,
   input  logic [CHAR_W-1:0]    req_char2,
   input  logic [CHAR_W-1:0]    req_char3,
   input  logic [CHAR_W-1:0]    req_char4,
   input  logic [CHAR_W-1:0]    req_char5,
   input  logic [CHAR_W-1:0]    req_char6,
   input  logic [CHAR_W-1:0]    req_char7,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [IDX_OUT_W-1:0] rsp_entry_index,
   output logic [TOT_OUT_W-1:0] rsp_match_total,
   output logic                 rsp_last
);

   localparam int NAME_W = NAME_CHARS * CHAR_W;
   localparam int KIND_W = $bits(op_kind_type);
   localparam int WORD_W = KIND_W + NAME_W;

   op_kind_type       in_kind;
   logic [NAME_W-1:0] in_name;
   logic [WORD_W-1:0] q_data;
   logic              q_valid, q_ready;

   wnlt_front #(
      .NAME_CHARS (NAME_CHARS)
   ) u_front (
      .req_type  (req_type),
      .req_char0 (req_char0),
      .req_char1 (req_char1),
      .req_char2 (req_char2),
      .req_char3 (req_char3),
      .req_char4 (req_char4),
      .req_char5 (req_char5),
      .req_char6 (req_char6),
      .req_char7 (req_char7),
      .kind      (in_kind),
      .name      (in_name)
   );

   wnlt_queue #(
      .WIDTH (WORD_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  ({in_kind, in_name}),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   wnlt_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .NAME_CHARS  (NAME_CHARS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_ready         (q_ready),
      .q_kind          (op_kind_type'(q_data[WORD_W-1 -: KIND_W])),
      .q_name          (q_data[NAME_W-1:0]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_entry_index (rsp_entry_index),
      .rsp_match_total (rsp_match_total),
      .rsp_last        (rsp_last)
   );

endmodule
